// ===== design/miss_table_signature_store_unit_assert.svh =====
// Assertion macros for the miss table RTL, used by mtss_back.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef MISS_TABLE_SIGNATURE_STORE_UNIT_ASSERT_SVH
`define MISS_TABLE_SIGNATURE_STORE_UNIT_ASSERT_SVH

// check a property on every clock outside reset
`define MTSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition holds in the cycle after a trigger
`define MTSS_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) trig |=> cons) else $error(msg);

`endif

// ===== design/mtss_pkg.sv =====
// Package for the signature miss table: command codes, item types, queue depth.
// No dependencies.
`default_nettype none
package mtss_pkg;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_TOUCH   = 2'd1;
  localparam logic [1:0] CMD_LOOKUP  = 2'd2;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_TOUCH,
    OP_LOOKUP,
    OP_OTHER
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] signature;
    logic [4:0]  addr_upper;
    logic [11:0] addr_lower;
  } item_t;

endpackage
`default_nettype wire

// ===== design/mtss_front.sv =====
// Front end: takes input beats, decodes the command and holds one item for the queue.
// Depends on mtss_pkg.
`default_nettype none
module mtss_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [39:0]    in_tdata,   // signature[15:0], addr_upper[20:16], addr_lower[32:21]
  input  wire logic [1:0]     in_tuser,   // cmd[1:0]
  output logic                push_valid,
  input  wire logic           push_ready,
  output mtss_pkg::item_t     push_item
);
  import mtss_pkg::*;

  logic  hold_v_r;
  item_t hold_r;
  op_t   op_dec;

  always_comb begin
    case (in_tuser)
      CMD_INSERT: op_dec = OP_INSERT;
      CMD_TOUCH:  op_dec = OP_TOUCH;
      CMD_LOOKUP: op_dec = OP_LOOKUP;
      default:    op_dec = OP_OTHER;
    endcase
  end

  assign in_tready  = !hold_v_r || push_ready;
  assign push_valid = hold_v_r;
  assign push_item  = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_tready) begin
      hold_v_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      hold_r.op         <= op_dec;
      hold_r.signature  <= in_tdata[15:0];
      hold_r.addr_upper <= in_tdata[20:16];
      hold_r.addr_lower <= in_tdata[32:21];
    end
  end

endmodule
`default_nettype wire

// ===== design/mtss_queue.sv =====
// Short FIFO between the front end and the table sequencer.
// Depends on mtss_pkg.
`default_nettype none
module mtss_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire mtss_pkg::item_t wr_item,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output mtss_pkg::item_t     rd_item
);
  import mtss_pkg::*;

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  item_t        slot_r [QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          do_wr, do_rd;

  assign wr_ready = cnt_r != (AW+1)'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_item  = slot_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == AW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == AW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (do_wr) begin
      slot_r[wp_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

// ===== design/mtss_back.sv =====
// Table sequencer: signature, rank and vector memories, valid bits, result register.
// Depends on mtss_pkg and the assertion macro header.
`default_nettype none
`include "miss_table_signature_store_unit_assert.svh"
module mtss_back #(
  parameter int SETS       = 32,
  parameter int WAYS       = 4,
  parameter int VECTORS    = 4,
  parameter int SIG_BITS   = 16,
  parameter int LOWER_BITS = 12
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  output logic                 q_ready,
  input  wire mtss_pkg::item_t q_item,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [23:0]          out_tdata,
  output logic                 out_tlast,
  output logic [0:0]           out_tuser
);
  import mtss_pkg::*;

  localparam int ENTRIES = SETS * WAYS;
  localparam int SW   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int EW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int VW   = 5 + LOWER_BITS + 8;
  localparam int POS  = VECTORS * 9;
  localparam int SUMW = LOWER_BITS + 4;

  typedef enum logic [1:0] {S_IDLE, S_TAG, S_VEC, S_EMIT} st_t;

  st_t                      st_r, st_nxt;
  op_t                      op_r;
  logic [SIG_BITS-1:0]      sig_r;
  logic [4:0]               up_r;
  logic [LOWER_BITS-1:0]    lo_r;
  logic [SW-1:0]            set_r;
  logic [EW-1:0]            ent_r, ent_nxt;
  logic                     alloc_r, alloc_nxt;
  logic [POS-1:0]           rem_r, rem_nxt;

  logic [ENTRIES-1:0]       valid_r;

  logic [WAYS*WW-1:0]       rank_mem [SETS];
  logic [WAYS*WW-1:0]       rank_rd_r, rank_new;
  logic [WAYS*SIG_BITS-1:0] sig_mem [SETS];
  logic [WAYS*SIG_BITS-1:0] sig_rd_r;
  logic [VECTORS*VW-1:0]    vec_mem [ENTRIES];
  logic [VECTORS*VW-1:0]    vec_rd_r;

  logic                     out_v_r;
  logic                     o_acc_r, o_fnd_r, o_ov_r, o_last_r;
  logic [4:0]               o_up_r;
  logic [11:0]              o_lo_r;

  logic                     out_free, ld;
  logic                     ld_acc, ld_fnd, ld_ov, ld_last;
  logic [4:0]               ld_up;
  logic [11:0]              ld_lo;

  logic                     hit;
  logic [WW-1:0]            hit_way, vic_way, way_sel;
  logic                     any_inv;
  logic                     promote;
  logic                     sig_we, vec_re, vec_we;
  logic [VECTORS*VW-1:0]    row, row_new;
  logic                     acc;
  logic [4:0]               bu;
  logic [LOWER_BITS-1:0]    bl, dlt;
  logic [7:0]               mk;
  logic [POS-1:0]           bits, pick;
  logic                     got;
  logic [4:0]               e_up;
  logic [LOWER_BITS-1:0]    e_lo;
  logic [3:0]               e_k;
  logic [SW-1:0]            q_set;
  logic [SIG_BITS-1:0]      q_sig;

  assign out_free = !out_v_r || out_tready;
  assign q_ready  = st_r == S_IDLE;
  assign q_sig    = SIG_BITS'(q_item.signature);
  assign q_set    = SW'(q_sig % SETS);

  // tag compare and victim choice for the set in flight
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    any_inv = 1'b0;
    vic_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && valid_r[EW'(set_r * WAYS + w)] &&
          sig_rd_r[w*SIG_BITS +: SIG_BITS] == sig_r) begin
        hit     = 1'b1;
        hit_way = WW'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!any_inv && !valid_r[EW'(set_r * WAYS + w)]) begin
        any_inv = 1'b1;
        vic_way = WW'(w);
      end
    end
    if (!any_inv) begin
      for (int w = 1; w < WAYS; w++) begin
        if (rank_rd_r[w*WW +: WW] > rank_rd_r[int'(vic_way)*WW +: WW]) begin
          vic_way = WW'(w);
        end
      end
    end
    way_sel = hit ? hit_way : vic_way;
  end

  // age every valid way younger than the promoted one (every valid way if it was invalid), then make it the youngest
  always_comb begin
    rank_new = rank_rd_r;
    for (int w = 0; w < WAYS; w++) begin
      if (WW'(w) != way_sel && valid_r[EW'(set_r * WAYS + w)] &&
          (!valid_r[EW'(set_r * WAYS + way_sel)] ||
           rank_rd_r[w*WW +: WW] < rank_rd_r[int'(way_sel)*WW +: WW])) begin
        rank_new[w*WW +: WW] = rank_rd_r[w*WW +: WW] + 1'b1;
      end
    end
    rank_new[int'(way_sel)*WW +: WW] = '0;
  end

  // offer the insert address to each vector in turn
  always_comb begin
    row     = alloc_r ? '0 : vec_rd_r;
    row_new = row;
    acc     = 1'b0;
    dlt     = '0;
    bu      = '0;
    bl      = '0;
    mk      = '0;
    for (int v = 0; v < VECTORS; v++) begin
      bu = row[v*VW +: 5];
      bl = row[v*VW + 5 +: LOWER_BITS];
      mk = row[v*VW + 5 + LOWER_BITS +: 8];
      if (!acc) begin
        if (bu == '0) begin
          bu  = up_r;
          bl  = lo_r;
          acc = 1'b1;
        end else if (bu == up_r && lo_r >= bl) begin
          dlt = lo_r - bl;
          if (dlt == '0) begin
            acc = 1'b1;
          end else if (dlt <= LOWER_BITS'(8)) begin
            mk[3'(dlt - 1'b1)] = 1'b1;
            acc = 1'b1;
          end
        end
      end
      row_new[v*VW +: VW] = {mk, bl, bu};
    end
  end

  // address map of the entry and the next address to emit
  always_comb begin
    bits = '0;
    for (int v = 0; v < VECTORS; v++) begin
      if (vec_rd_r[v*VW +: 5] != '0) begin
        bits[v*9] = 1'b1;
        for (int k = 0; k < 8; k++) begin
          bits[v*9 + k + 1] = vec_rd_r[v*VW + 5 + LOWER_BITS + k];
        end
      end
    end
    got  = 1'b0;
    pick = '0;
    e_up = '0;
    e_lo = '0;
    e_k  = '0;
    for (int v = 0; v < VECTORS; v++) begin
      for (int k = 0; k < 9; k++) begin
        if (!got && rem_r[v*9 + k]) begin
          got           = 1'b1;
          pick[v*9 + k] = 1'b1;
          e_up          = vec_rd_r[v*VW +: 5];
          e_lo          = vec_rd_r[v*VW + 5 +: LOWER_BITS];
          e_k           = 4'(k);
        end
      end
    end
  end

  always_comb begin
    st_nxt    = st_r;
    ent_nxt   = ent_r;
    alloc_nxt = alloc_r;
    rem_nxt   = rem_r;
    promote   = 1'b0;
    sig_we    = 1'b0;
    vec_re    = 1'b0;
    vec_we    = 1'b0;
    ld        = 1'b0;
    ld_acc    = 1'b0;
    ld_fnd    = 1'b0;
    ld_ov     = 1'b0;
    ld_last   = 1'b1;
    ld_up     = '0;
    ld_lo     = '0;
    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          st_nxt = S_TAG;
        end
      end
      S_TAG: begin
        ent_nxt   = EW'(set_r * WAYS + way_sel);
        alloc_nxt = !hit;
        case (op_r)
          OP_INSERT: begin
            promote = 1'b1;
            sig_we  = !hit;
            vec_re  = 1'b1;
            st_nxt  = S_VEC;
          end
          OP_LOOKUP: begin
            if (hit) begin
              vec_re = 1'b1;
              st_nxt = S_VEC;
            end else if (out_free) begin
              ld     = 1'b1;
              st_nxt = S_IDLE;
            end
          end
          OP_TOUCH: begin
            if (out_free) begin
              promote = hit;
              ld      = 1'b1;
              ld_fnd  = hit;
              st_nxt  = S_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              ld     = 1'b1;
              st_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_VEC: begin
        if (op_r == OP_INSERT) begin
          if (out_free) begin
            vec_we = 1'b1;
            ld     = 1'b1;
            ld_acc = acc;
            st_nxt = S_IDLE;
          end
        end else if (bits == '0) begin
          if (out_free) begin
            ld     = 1'b1;
            ld_fnd = 1'b1;
            st_nxt = S_IDLE;
          end
        end else begin
          rem_nxt = bits;
          st_nxt  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_fnd  = 1'b1;
          ld_ov   = 1'b1;
          ld_up   = e_up;
          ld_lo   = 12'(SUMW'(e_lo) + SUMW'(e_k));
          rem_nxt = rem_r & ~pick;
          ld_last = rem_nxt == '0;
          if (ld_last) begin
            st_nxt = S_IDLE;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      out_v_r <= 1'b0;
      valid_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (ld) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (promote) begin
        valid_r[EW'(set_r * WAYS + way_sel)] <= 1'b1;
      end
    end
    if (st_r == S_IDLE && q_valid) begin
      op_r      <= q_item.op;
      sig_r     <= q_sig;
      up_r      <= q_item.addr_upper;
      lo_r      <= LOWER_BITS'(q_item.addr_lower);
      set_r     <= q_set;
      sig_rd_r  <= sig_mem[q_set];
      rank_rd_r <= rank_mem[q_set];
    end
    ent_r   <= ent_nxt;
    alloc_r <= alloc_nxt;
    rem_r   <= rem_nxt;
    if (promote) begin
      rank_mem[set_r] <= rank_new;
    end
    if (sig_we) begin
      for (int w = 0; w < WAYS; w++) begin
        if (WW'(w) == way_sel) begin
          sig_mem[set_r][w*SIG_BITS +: SIG_BITS] <= sig_r;
        end
      end
    end
    if (vec_re) begin
      vec_rd_r <= vec_mem[ent_nxt];
    end
    if (vec_we) begin
      vec_mem[ent_r] <= row_new;
    end
    if (ld) begin
      o_acc_r  <= ld_acc;
      o_fnd_r  <= ld_fnd;
      o_ov_r   <= ld_ov;
      o_up_r   <= ld_up;
      o_lo_r   <= ld_lo;
      o_last_r <= ld_last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, o_lo_r, o_up_r, o_fnd_r, o_acc_r};
  assign out_tlast  = o_last_r;
  assign out_tuser  = o_ov_r;

  `MTSS_ASSERT(a_ld_free, ld |-> out_free, "result over an untaken beat")
  `MTSS_ASSERT(a_vec_we_insert, vec_we |-> (st_r == S_VEC && op_r == OP_INSERT), "stray write")
  `MTSS_ASSERT(a_emit_last, (st_r == S_EMIT && ld && ld_last) |-> (st_nxt == S_IDLE), "no finish")
  `MTSS_ASSERT_NEXT(a_pop_tag, (st_r == S_IDLE && q_valid), (st_r == S_TAG), "item not looked up")

endmodule
`default_nettype wire

// ===== design/miss_table_signature_store_unit.sv =====
// Channel | dir | handshake         | payload
// in_     | in  | tvalid/tready     | tuser: cmd; tdata: signature, addr_upper, addr_lower
// out_    | out | tvalid/tready     | tuser: out_valid; tdata: accepted, found, out_upper,
//         |     |                   | out_lower; tlast: last
// Each item reads the sequencer's signature and rank memories (touch, unknown, lookup miss
// end there); inserts and lookup hits then read the vector memory, and a lookup hit emits
// one beat per stored address, or one beat if it has none. Synchronous active-low reset
// clears the valid bits at once; ranks, tags and vectors are read only for valid ways, so
// no clearing pass. A stalled output holds the sequencer, the queue and front end keep
// accepting until full.
// Depends on mtss_pkg, mtss_front, mtss_queue, mtss_back.
`default_nettype none
module miss_table_signature_store_unit #(
  parameter int SETS       = 32,
  parameter int WAYS       = 4,
  parameter int VECTORS    = 4,
  parameter int SIG_BITS   = 16,
  parameter int LOWER_BITS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // signature[15:0], addr_upper[20:16], addr_lower[32:21]
  input  wire logic [1:0]  in_tuser,   // cmd[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // accepted[0], found[1], out_upper[6:2], out_lower[18:7]
  output logic             out_tlast,
  output logic [0:0]       out_tuser   // out_valid[0]
);
  import mtss_pkg::*;

  logic  f_valid, f_ready, b_valid, b_ready;
  item_t f_item, b_item;

  mtss_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item)
  );

  mtss_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_item  (b_item)
  );

  mtss_back #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .VECTORS    (VECTORS),
    .SIG_BITS   (SIG_BITS),
    .LOWER_BITS (LOWER_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_item     (b_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// ===== dv/mtss_checker.sv =====
// Checker for the signature miss table: watches both stream channels, keeps its own
// copy of the table, predicts every output beat and compares. Depends on mtss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mtss_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [39:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,
  input  wire logic        out_tlast,
  input  wire logic [0:0]  out_tuser,
  output int               mismatches,
  output int               pending,
  output int               beats_seen
);
  import mtss_pkg::*;

  localparam int SETS = 32;
  localparam int WAYS = 4;
  localparam int VECS = 4;

  typedef struct packed {
    logic        accepted;
    logic        found;
    logic        addr_ok;
    logic [4:0]  upper;
    logic [11:0] lower;
    logic        last;
  } beat_t;

  logic        tag_valid [SETS*WAYS];
  logic [15:0] tag_sig   [SETS*WAYS];
  logic [1:0]  age       [SETS*WAYS];
  logic [4:0]  vec_upper [SETS*WAYS*VECS];
  logic [11:0] vec_lower [SETS*WAYS*VECS];
  logic [7:0]  vec_mask  [SETS*WAYS*VECS];
  beat_t       expected_beats[$];

  function automatic void queue_beat(beat_t b);
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  function automatic int find_way(int set_base, logic [15:0] sig);
    for (int w = 0; w < WAYS; w++)
      if (tag_valid[set_base+w] && tag_sig[set_base+w] == sig) return w;
    return -1;
  endfunction

  function automatic void make_recent(int set_base, int way);
    int old_age;
    old_age = tag_valid[set_base+way] ? int'(age[set_base+way]) : WAYS;
    for (int w = 0; w < WAYS; w++)
      if (w != way && tag_valid[set_base+w] && int'(age[set_base+w]) < old_age)
        age[set_base+w] = age[set_base+w] + 2'd1;
    age[set_base+way] = 2'd0;
  endfunction

  function automatic int claim_way(int set_base, logic [15:0] sig);
    int victim;
    victim = -1;
    for (int w = 0; w < WAYS && victim < 0; w++)
      if (!tag_valid[set_base+w]) victim = w;
    if (victim < 0) begin
      victim = 0;
      for (int w = 1; w < WAYS; w++)
        if (age[set_base+w] > age[set_base+victim]) victim = w;
    end
    make_recent(set_base, victim);
    tag_valid[set_base+victim] = 1'b1;
    tag_sig[set_base+victim] = sig;
    for (int v = 0; v < VECS; v++) begin
      vec_upper[(set_base+victim)*VECS+v] = '0;
      vec_lower[(set_base+victim)*VECS+v] = '0;
      vec_mask[(set_base+victim)*VECS+v] = '0;
    end
    return victim;
  endfunction

  function automatic logic offer_line(int idx, logic [4:0] up, logic [11:0] lo);
    int line_gap;
    if (vec_upper[idx] == 5'd0) begin
      vec_upper[idx] = up;
      vec_lower[idx] = lo;
      return 1'b1;
    end
    if (vec_upper[idx] != up || lo < vec_lower[idx]) return 1'b0;
    line_gap = int'(lo) - int'(vec_lower[idx]);
    if (line_gap == 0) return 1'b1;
    if (line_gap > 8) return 1'b0;
    vec_mask[idx][line_gap-1] = 1'b1;
    return 1'b1;
  endfunction

  task automatic predict_table(logic [1:0] cmd, logic [15:0] sig, logic [4:0] up,
                               logic [11:0] lo);
    int set_base, way, idx, n;
    logic took;
    beat_t b;
    set_base = int'(sig % SETS) * WAYS;
    way = find_way(set_base, sig);
    b = '0;
    b.last = 1'b1;
    case (cmd)
      CMD_INSERT: begin
        if (way < 0) way = claim_way(set_base, sig);
        else make_recent(set_base, way);
        took = 1'b0;
        for (int v = 0; v < VECS && !took; v++)
          took = offer_line((set_base+way)*VECS+v, up, lo);
        b.accepted = took;
        queue_beat(b);
      end
      CMD_TOUCH: begin
        if (way >= 0) make_recent(set_base, way);
        b.found = (way >= 0);
        queue_beat(b);
      end
      CMD_LOOKUP: begin
        if (way < 0) begin
          queue_beat(b);
        end else begin
          n = 0;
          for (int v = 0; v < VECS; v++) begin
            idx = (set_base+way)*VECS+v;
            if (vec_upper[idx] == 5'd0) continue;
            b = '0;
            b.found = 1'b1;
            b.addr_ok = 1'b1;
            b.upper = vec_upper[idx];
            b.lower = vec_lower[idx];
            queue_beat(b);
            n++;
            for (int k = 0; k < 8; k++)
              if (vec_mask[idx][k]) begin
                b.lower = vec_lower[idx] + 12'(k + 1);
                queue_beat(b);
                n++;
              end
          end
          if (n == 0) begin
            b = '0;
            b.found = 1'b1;
            b.last = 1'b1;
            queue_beat(b);
          end else begin
            expected_beats[$].last = 1'b1;
          end
        end
      end
      default: queue_beat(b);
    endcase
  endtask

  always @(posedge clk) begin
    beat_t got, want;
    if (!rst_n) begin
      for (int e = 0; e < SETS*WAYS; e++) begin
        tag_valid[e] = 1'b0;
        tag_sig[e] = '0;
        age[e] = '0;
      end
      for (int e = 0; e < SETS*WAYS*VECS; e++) begin
        vec_upper[e] = '0;
        vec_lower[e] = '0;
        vec_mask[e] = '0;
      end
      expected_beats.delete();
      mismatches = 0;
      beats_seen = 0;
    end else begin
      if (in_tvalid && in_tready)
        predict_table(in_tuser, in_tdata[15:0], in_tdata[20:16], in_tdata[32:21]);
      if (out_tvalid && out_tready) begin
        got.accepted = out_tdata[0];
        got.found    = out_tdata[1];
        got.upper    = out_tdata[6:2];
        got.lower    = out_tdata[18:7];
        got.addr_ok  = out_tuser[0];
        got.last     = out_tlast;
        beats_seen++;
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output beat %p", got);
        end else begin
          want = expected_beats[0];
          expected_beats.delete(0);
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("beat mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
    pending = expected_beats.size();
  end
endmodule
`default_nettype wire

// ===== dv/miss_table_signature_store_unit_test.sv =====
// Testbench top: drives directed and random commands with random gaps and stalls, and
// reports the verdict. Uses mtss_pkg, mtss_checker, miss_table_signature_store_unit.
`timescale 1ns / 1ps
`default_nettype none
module miss_table_signature_store_unit_test;
  import mtss_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;    // signature, addr_upper, addr_lower
  logic [1:0]  in_tuser = '0;    // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // accepted, found, out_upper, out_lower
  logic        out_tlast;
  logic [0:0]  out_tuser;        // out_valid
  int          mismatches, pending, beats_seen;
  int          items_sent = 0;
  bit          calm = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  miss_table_signature_store_unit dut (.*);

  mtss_checker table_check (.*);

  // Drop valid only for a real gap, so back-to-back beats keep it high.
  task automatic send_item(logic [1:0] cmd, logic [15:0] sig, logic [4:0] up,
                           logic [11:0] lo);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, lo, up, sig};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Signatures from a small pool that crowds a few sets, so eviction is exercised.
  function automatic logic [15:0] pick_sig();
    return {11'($urandom_range(0, 5)), 5'($urandom_range(0, 2))};
  endfunction

  // Stall the result side for a random gap before each beat.
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      hold = calm ? 0 : $urandom_range(0, 14);
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    logic [15:0] s;
    logic [4:0]  u;
    logic [11:0] l;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: misses, invalid address, window edges, extremes, unknown command
    send_item(CMD_LOOKUP, 16'hFFFF, 5'd0, 12'd0);
    send_item(CMD_TOUCH, 16'hFFFF, 5'd0, 12'd0);
    send_item(CMD_INSERT, 16'hFFFF, 5'd0, 12'hFFF);
    send_item(CMD_LOOKUP, 16'hFFFF, 5'd0, 12'd0);
    send_item(CMD_INSERT, 16'hFFFF, 5'd31, 12'd100);
    send_item(CMD_INSERT, 16'hFFFF, 5'd31, 12'd108);
    send_item(CMD_INSERT, 16'hFFFF, 5'd31, 12'd109);
    send_item(CMD_INSERT, 16'hFFFF, 5'd31, 12'd99);
    send_item(CMD_INSERT, 16'hFFFF, 5'd31, 12'd101);
    send_item(CMD_INSERT, 16'hFFFF, 5'd31, 12'd100);
    send_item(CMD_INSERT, 16'hFFFF, 5'd7, 12'hFFF);
    send_item(CMD_INSERT, 16'hFFFF, 5'd0, 12'd5);
    send_item(CMD_LOOKUP, 16'hFFFF, 5'd0, 12'd0);
    send_item(CMD_UNKNOWN, 16'hFFFF, 5'd31, 12'hFFF);
    for (int k = 0; k < 5; k++)
      send_item(CMD_INSERT, 16'(k * 32 + 1), 5'd1, 12'd0);
    send_item(CMD_TOUCH, 16'h0021, 5'd0, 12'd0);
    send_item(CMD_LOOKUP, 16'h0001, 5'd0, 12'd0);
    send_item(CMD_LOOKUP, 16'h0021, 5'd0, 12'd0);
    for (int n = 0; n < 340; n++) begin
      calm = (n / 40) % 4 == 3;
      s = ($urandom_range(0, 9) == 0) ? 16'($urandom) : pick_sig();
      u = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3));
      l = ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                      : 12'(s[7:0] * 4 + $urandom_range(0, 20));
      case ($urandom_range(0, 19))
        0:              send_item(CMD_UNKNOWN, s, u, l);
        1, 2, 3:        send_item(CMD_TOUCH, s, u, l);
        4, 5, 6, 7, 8:  send_item(CMD_LOOKUP, s, u, l);
        default:        send_item(CMD_INSERT, s, u, l);
      endcase
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d commands (insert, touch, lookup, unknown); checked %0d result beats.",
             items_sent, beats_seen);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
